// ===== src/phs_pkg.sv =====
package phs_pkg;

  localparam int SAMPLE_W = 16;
  localparam int LEVEL_W  = 17;
  localparam int BAND_W   = 15;
  localparam int VALUE_W  = 32;
  localparam int DIFF_W   = VALUE_W + 1;
  localparam int FRAC_W   = 17;
  localparam int MOP_W    = 33;
  localparam int PROD_W   = 64;
  localparam int CFG_IDX_W = 2;

  localparam logic [FRAC_W-1:0] FRAC_ONE = 17'd65536;
  localparam logic signed [LEVEL_W:0] FRAC_HALF = 18'sd32768;

  localparam logic [VALUE_W-1:0] OUT_MIN_RESET = 32'd0;
  localparam logic [VALUE_W-1:0] OUT_MAX_RESET = 32'd65536;
  localparam logic [BAND_W-1:0]  BAND_RESET    = 15'd512;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LOG_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_MIN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_MAX  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BAND     = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TRACK,
    ST_FRAC,
    ST_QUAD,
    ST_ROUND,
    ST_MAP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic track;
    logic frac;
    logic quad;
    logic round;
    logic map;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic log_small;
    logic out_free;
  } status_t;

endpackage

// ===== src/phs_if.sv =====
interface phs_sample_if;
  logic valid;
  logic ready;
  logic signed [phs_pkg::SAMPLE_W-1:0] raw_sample;
  modport source (output valid, output raw_sample, input ready);
  modport sink (input valid, input raw_sample, output ready);
endinterface

interface phs_result_if;
  logic valid;
  logic ready;
  logic signed [phs_pkg::VALUE_W-1:0] scaled_value;
  modport source (output valid, output scaled_value, input ready);
  modport sink (input valid, input scaled_value, output ready);
endinterface

// ===== src/phs_ctrl.sv =====
module phs_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  phs_pkg::status_t  sts,
  output phs_pkg::cmd_t     cmd
);

  phs_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= phs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      phs_pkg::ST_IDLE:  if (in_valid) state_next = phs_pkg::ST_TRACK;
      phs_pkg::ST_TRACK: state_next = sts.hit ? phs_pkg::ST_FRAC : phs_pkg::ST_IDLE;
      phs_pkg::ST_FRAC:  state_next = sts.log_small ? phs_pkg::ST_QUAD : phs_pkg::ST_MAP;
      phs_pkg::ST_QUAD:  state_next = phs_pkg::ST_ROUND;
      phs_pkg::ST_ROUND: state_next = phs_pkg::ST_MAP;
      phs_pkg::ST_MAP:   state_next = phs_pkg::ST_DONE;
      phs_pkg::ST_DONE:  if (sts.out_free) state_next = phs_pkg::ST_IDLE;
      default:           state_next = phs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      phs_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      phs_pkg::ST_TRACK: cmd.track = 1'b1;
      phs_pkg::ST_FRAC:  cmd.frac  = 1'b1;
      phs_pkg::ST_QUAD:  cmd.quad  = 1'b1;
      phs_pkg::ST_ROUND: cmd.round = 1'b1;
      phs_pkg::ST_MAP:   cmd.map   = 1'b1;
      phs_pkg::ST_DONE:  cmd.emit  = sts.out_free;
      default: begin
        cmd      = '0;
        in_ready = 1'b0;
      end
    endcase
  end

`ifndef SYNTH
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> state == phs_pkg::ST_TRACK)
    else $error("accepted beat did not start tracking");

  a_no_hit_idle: assert property (@(posedge clk) disable iff (rst)
    (state == phs_pkg::ST_TRACK && !sts.hit) |=> state == phs_pkg::ST_IDLE)
    else $error("no level move but work continued");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (state == phs_pkg::ST_DONE && !sts.out_free) |=> state == phs_pkg::ST_DONE)
    else $error("result dropped while output register full");

  a_ready_only_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> (state == phs_pkg::ST_IDLE && !cmd.emit))
    else $error("input ready outside idle");
`endif

endmodule

// ===== src/phs_dp.sv =====
module phs_dp (
  input  logic                                   clk,
  input  logic                                   rst,
  input  phs_pkg::cmd_t                          cmd,
  output phs_pkg::status_t                       sts,
  input  logic signed [phs_pkg::SAMPLE_W-1:0]    raw_sample,
  input  logic                                   cfg_we,
  input  logic [phs_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [phs_pkg::VALUE_W-1:0]            cfg_data,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [phs_pkg::VALUE_W-1:0]     scaled_value
);

  localparam int LW = phs_pkg::LEVEL_W;
  localparam int SUM_W = phs_pkg::PROD_W - 16 + 1;

  // configuration
  logic                                 log_mode;
  logic signed [phs_pkg::VALUE_W-1:0]   out_min;
  logic signed [phs_pkg::VALUE_W-1:0]   out_max;
  logic [phs_pkg::BAND_W-1:0]           band;
  logic signed [phs_pkg::DIFF_W-1:0]    diff;

  always_ff @(posedge clk) begin
    if (rst) begin
      log_mode <= 1'b0;
      out_min  <= phs_pkg::OUT_MIN_RESET;
      out_max  <= phs_pkg::OUT_MAX_RESET;
      band     <= phs_pkg::BAND_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        phs_pkg::REG_LOG_MODE: log_mode <= cfg_data[0];
        phs_pkg::REG_OUT_MIN:  out_min  <= cfg_data;
        phs_pkg::REG_OUT_MAX:  out_max  <= cfg_data;
        phs_pkg::REG_BAND:     band     <= cfg_data[phs_pkg::BAND_W-1:0];
        default: ;
      endcase
    end
  end

  // range width, only read long after any config write
  always_ff @(posedge clk) begin
    diff <= {out_max[phs_pkg::VALUE_W-1], out_max} - {out_min[phs_pkg::VALUE_W-1], out_min};
  end

  // tracking
  logic signed [phs_pkg::SAMPLE_W-1:0] raw_reg;
  logic signed [LW-1:0]                level;
  logic signed [LW:0]                  raw_x, band_x, hi_lim, lo_lim, level_new;
  logic                                up, dn;

  assign raw_x  = LW'(raw_reg) + 18'sd0;
  assign band_x = {3'b000, band};
  assign hi_lim = {level[LW-1], level} + band_x;
  assign lo_lim = {level[LW-1], level} - band_x;
  assign up     = raw_x > hi_lim;
  assign dn     = raw_x < lo_lim;

  always_comb begin
    if (up) begin
      level_new = raw_x - band_x;
    end else if (dn) begin
      level_new = raw_x + band_x;
    end else begin
      level_new = {level[LW-1], level};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      raw_reg <= raw_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level <= '0;
    end else if (cmd.track) begin
      level <= level_new[LW-1:0];
    end
  end

  // fraction
  logic signed [LW:0]             f;
  logic [LW-1:0]                  abs_f;
  logic [phs_pkg::FRAC_W-1:0]     p_lin;
  logic [phs_pkg::FRAC_W-1:0]     p;

  assign f     = {level[LW-1], level} + phs_pkg::FRAC_HALF;
  assign abs_f = f[LW] ? LW'(-f) : f[LW-1:0];

  always_comb begin
    if (f[LW]) begin
      p_lin = '0;
    end else if (f[LW-1:0] > phs_pkg::FRAC_ONE) begin
      p_lin = phs_pkg::FRAC_ONE;
    end else begin
      p_lin = f[LW-1:0];
    end
  end

  // shared multiplier
  logic [phs_pkg::PROD_W-1:0]           mreg;
  logic signed [phs_pkg::MOP_W-1:0]     op_a, op_b;
  logic signed [2*phs_pkg::MOP_W-1:0]   prod;
  logic [phs_pkg::PROD_W:0]             rnd;

  always_comb begin
    if (cmd.quad) begin
      op_a = {1'b0, mreg[31:0]};
      op_b = {1'b0, mreg[31:0]};
    end else if (cmd.map) begin
      op_a = {16'd0, p};
      op_b = diff;
    end else begin
      op_a = {17'd0, abs_f[15:0]};
      op_b = {17'd0, abs_f[15:0]};
    end
  end

  assign prod = op_a * op_b;
  assign rnd  = {1'b0, mreg} + (65'd1 << 47);

  always_ff @(posedge clk) begin
    if (cmd.frac || cmd.quad || cmd.map) begin
      mreg <= prod[phs_pkg::PROD_W-1:0];
    end
    if (cmd.frac) begin
      p <= log_mode ? phs_pkg::FRAC_ONE : p_lin;
    end else if (cmd.round) begin
      p <= rnd[phs_pkg::PROD_W:48];
    end
  end

  // q = floor((x + 2^15) / 2^16) = (x >>> 16) + x[15]
  logic signed [SUM_W-1:0] sum;
  logic signed [phs_pkg::VALUE_W-1:0] sat;

  assign sum = {{(SUM_W-phs_pkg::VALUE_W){out_min[phs_pkg::VALUE_W-1]}}, out_min}
             + {mreg[phs_pkg::PROD_W-1], mreg[phs_pkg::PROD_W-1:16]}
             + {{(SUM_W-1){1'b0}}, mreg[15]};

  always_comb begin
    if (sum > SUM_W'(64'sh7FFF_FFFF)) begin
      sat = 32'sh7FFF_FFFF;
    end else if (sum < -SUM_W'(64'sh8000_0000)) begin
      sat = 32'sh8000_0000;
    end else begin
      sat = sum[phs_pkg::VALUE_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      scaled_value <= sat;
    end
  end

  assign sts.hit       = up | dn;
  assign sts.log_small = log_mode & ~abs_f[LW-1];
  assign sts.out_free  = ~out_valid | out_ready;

endmodule

// ===== src/pot_hysteresis_scaler.sv =====
// Knob sample hysteresis filter and range scaler.
//
// samples (sink): one signed 16-bit raw_sample per beat. The tracked level
//   moves only when the sample leaves [level - band, level + band], then
//   sits one band behind it. No move, no result.
// results (source): one signed Q16.16 scaled_value per level move,
//   out_min + frac * (out_max - out_min), frac linear or its fourth power.
// cfg: cfg_we / cfg_index / cfg_data, index 0 log_mode, 1 out_min,
//   2 out_max, 3 band. Write only while idle.
// Timing: one beat at a time. Accept, then TRACK, FRAC, MAP, DONE in
//   linear mode (or log with a saturated fraction); with the log power
//   QUAD and ROUND come between FRAC and MAP (QUAD squares again on the
//   shared 33x33 multiplier, ROUND takes it back to Q16). A beat with no
//   move goes from TRACK back to idle, freeing the input. Next input is
//   taken the cycle after DONE.
// Stall: the output register holds a result until taken; a new sample is
//   still accepted and worked on, and waits in DONE only if the previous
//   result is still unread.
// Reset: rst synchronous; level 0, log_mode 0, out_min 0, out_max 1.0,
//   band 512, no pending result.
module pot_hysteresis_scaler (
  input  logic                                clk,
  input  logic                                rst,
  phs_sample_if.sink                          samples,
  phs_result_if.source                        results,
  input  logic                                cfg_we,
  input  logic [phs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [phs_pkg::VALUE_W-1:0]         cfg_data
);

  phs_pkg::cmd_t    cmd;
  phs_pkg::status_t sts;

  phs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (samples.valid),
    .in_ready (samples.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  phs_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .raw_sample   (samples.raw_sample),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .out_valid    (results.valid),
    .out_ready    (results.ready),
    .scaled_value (results.scaled_value)
  );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

// Self-checking bench for pot_hysteresis_scaler.
// A scoreboard object mirrors the tracked level and the four registers. Every
// accepted sample beat is run through its own copy of the hysteresis and
// mapping math. A beat that moves the level queues one expected scaled value.
// Each result beat taken from the block is checked against the oldest entry.

class knob_scoreboard;
  typedef struct {
    int                 seq;
    logic signed [31:0] value;
  } scaled_exp_t;

  // mirrored registers and state, kept wide and signed so the compares
  // below never fall into unsigned arithmetic
  bit          log_mode;
  longint      out_min;
  longint      out_max;
  longint      band_cnt;
  longint      level;

  scaled_exp_t expected_values[$];
  int          sample_seq;
  int          result_seq;
  int          error_count;

  function new();
    log_mode    = 1'b0;
    out_min     = 0;
    out_max     = 65536;
    band_cnt    = 512;
    level       = 0;
    sample_seq  = 0;
    result_seq  = 0;
    error_count = 0;
  endfunction

  task report(string msg);
    $display("MISMATCH: %s", msg);
    error_count++;
  endtask

  function void set_reg(logic [phs_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
    case (idx)
      phs_pkg::REG_LOG_MODE: log_mode = data[0];
      phs_pkg::REG_OUT_MIN:  out_min  = longint'($signed(data));
      phs_pkg::REG_OUT_MAX:  out_max  = longint'($signed(data));
      phs_pkg::REG_BAND:     band_cnt = longint'(data[14:0]);
      default: ;
    endcase
  endfunction

  function int pending();
    return expected_values.size();
  endfunction

  // Fraction in Q16, 65536 = 1.0. Log mode takes the fourth power of |f|,
  // rounded half up; a fraction at or past one saturates.
  function longint level_fraction(longint lvl);
    longint    f;
    bit [63:0] a;
    bit [63:0] a4;
    f = lvl + 32768;
    if (log_mode) begin
      a = (f < 0) ? -f : f;
      if (a >= 64'd65536) return 65536;
      a4 = a * a * a * a;
      return longint'((a4 + (64'd1 << 47)) >> 48);
    end
    if (f < 0) return 0;
    if (f > 65536) return 65536;
    return f;
  endfunction

  // Accepted sample beat: update the level, queue a value if it moved.
  function void note_sample(logic signed [15:0] raw);
    longint      s;
    longint      lvl;
    longint      p;
    longint      d;
    longint      q;
    longint      r;
    bit          moved;
    scaled_exp_t e;
    s     = longint'(raw);
    lvl   = level;
    moved = 1'b0;
    if (s > lvl + band_cnt) begin
      lvl   = s - band_cnt;
      moved = 1'b1;
    end
    if (s < lvl - band_cnt) begin
      lvl   = s + band_cnt;
      moved = 1'b1;
    end
    level = lvl;
    sample_seq++;
    if (!moved) return;
    p = level_fraction(lvl);
    d = out_max - out_min;
    // floor((p*d + half) / one), arithmetic shift gives the floor
    q = (p * d + 32768) >>> 16;
    r = out_min + q;
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    e.seq   = sample_seq;
    e.value = r[31:0];
    expected_values.push_back(e);
  endfunction

  task check_result(logic signed [31:0] got);
    scaled_exp_t e;
    result_seq++;
    if (expected_values.size() == 0) begin
      report($sformatf("result beat %0d: scaled_value %0d with nothing expected",
                       result_seq, got));
      return;
    end
    e = expected_values.pop_front();
    if (got !== e.value)
      report($sformatf("result beat %0d (sample %0d): scaled_value %0d, expected %0d",
                       result_seq, e.seq, got, e.value));
  endtask
endclass

module tb;

  localparam int CYCLE_LIMIT   = 1000000;
  // longest path runs TRACK, FRAC, QUAD, ROUND, MAP, DONE; leave margin before a write
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES   = 300;

  logic                          clk;
  logic                          rst;
  logic                          cfg_we;
  logic [phs_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [phs_pkg::VALUE_W-1:0]   cfg_data;

  phs_sample_if samples_if ();
  phs_result_if results_if ();

  pot_hysteresis_scaler u_top (
    .clk       (clk),
    .rst       (rst),
    .samples   (samples_if),
    .results   (results_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  knob_scoreboard sb;

  // knobs of the sender and the result taker; the first two are shared
  bit     no_idle;     // phase with no gaps on either side
  bit     hold_req;    // ask the result side for one long hold-off
  int     last_raw;    // last sample sent, seeds the random walk
  longint cycle_count;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Watchdog. A stuck handshake lands here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Gap length: mostly none or short, now and then a long one.
  function automatic int idle_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Random knob movement: part full-range noise, part jitter within a band of
  // the last sample, part steps clearly past a band from the last sample.
  function automatic logic signed [15:0] next_sample();
    int w;
    int v;
    int r;
    int step;
    w = int'(sb.band_cnt);
    r = $urandom_range(0, 99);
    if (r < 30) begin
      v = int'($urandom_range(0, 65535)) - 32768;
    end else if (r < 65) begin
      v = last_raw + int'($urandom_range(0, 2 * w)) - w;
    end else begin
      step = w + int'($urandom_range(1, 3000));
      v = ($urandom_range(0, 1) != 0) ? last_raw + step : last_raw - step;
    end
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    last_raw = v;
    return v[15:0];
  endfunction

  // One sample beat. Called at a falling edge, returns at a falling edge with
  // valid still high, so back-to-back beats need no second assignment.
  task automatic send_sample(input logic signed [15:0] raw);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      samples_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    samples_if.valid      <= 1'b1;
    samples_if.raw_sample <= raw;
    do @(posedge clk); while (!samples_if.ready);
    sb.note_sample(raw);
    last_raw = int'(raw);
    @(negedge clk);
  endtask

  // Stop offering and wait out every outstanding result.
  task automatic drain_results();
    samples_if.valid <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [phs_pkg::CFG_IDX_W-1:0] idx,
                           input logic [phs_pkg::VALUE_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    sb.set_reg(idx, data);
    @(negedge clk);
  endtask

  // Block must be idle here: the previous phase has drained and settled.
  // Upper bits beyond a register's width carry junk on purpose.
  task automatic configure(input bit lg, input logic [31:0] mn, input logic [31:0] mx,
                           input int bnd);
    write_reg(phs_pkg::REG_LOG_MODE, ($urandom & 32'hFFFF_FFFE) | 32'(lg));
    write_reg(phs_pkg::REG_OUT_MIN, mn);
    write_reg(phs_pkg::REG_OUT_MAX, mx);
    write_reg(phs_pkg::REG_BAND, ($urandom & 32'hFFFF_8000) | 32'(bnd[14:0]));
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic random_config();
    int r;
    int bnd;
    r = $urandom_range(0, 9);
    if (r < 7) bnd = $urandom_range(0, 600);
    else if (r < 9) bnd = $urandom_range(600, 4000);
    else bnd = $urandom_range(0, 32767);
    configure(1'($urandom_range(0, 1)), $urandom, $urandom, bnd);
  endtask

  // Random beats; hold_at asks for the long result hold-off, pause_at makes
  // the sender wait for all results. -1 means neither.
  task automatic run_random(input int count, input int hold_at, input int pause_at);
    for (int i = 0; i < count; i++) begin
      if (i == hold_at) hold_req = 1'b1;
      if (i == pause_at) drain_results();
      send_sample(next_sample());
    end
  endtask

  task automatic end_phase();
    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Result side: random ready with bursts, plus the one-off long hold.
  initial begin
    int stall;
    results_if.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_req) begin
        results_if.ready <= 1'b0;
        for (int i = 0; i < HOLD_CYCLES; i++) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        stall = idle_gap();
        if (stall > 0) begin
          results_if.ready <= 1'b0;
          repeat (stall) @(negedge clk);
        end
      end
      results_if.ready <= 1'b1;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
  end

  // Result beats are checked on the edge that takes them.
  always @(posedge clk) begin
    if (!rst && results_if.valid && results_if.ready)
      sb.check_result(results_if.scaled_value);
  end

  initial begin
    logic signed [15:0] dir_default[$];
    logic signed [15:0] dir_log[$];
    logic signed [15:0] dir_zero[$];

    // field extremes, edges of the default band, alternating bit patterns
    dir_default = '{16'sd0, 16'sd512, 16'sd513, 16'sd1000, 16'sd32767, 16'sd32767,
                    -16'sd32768, 16'sd0, -16'sd1, 16'sh5555, 16'shAAAA, 16'sd200,
                    -16'sd200, 16'sd0};
    // log curve: low end, top end, mid
    dir_log = '{-16'sd32768, 16'sd32767, -16'sd20000, 16'sd0, 16'sd10000};
    // zero band: repeats give nothing, any change moves the level
    dir_zero = '{16'sd5, 16'sd5, 16'sd6, -16'sd32768, 16'sd32767};

    sb                    = new();
    no_idle               = 1'b0;
    hold_req              = 1'b0;
    last_raw              = 0;
    cycle_count           = 0;
    rst                   = 1'b1;
    cfg_we                = 1'b0;
    cfg_index             = '0;
    cfg_data              = '0;
    samples_if.valid      = 1'b0;
    samples_if.raw_sample = '0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset values of all registers, no writes yet
    foreach (dir_default[i]) send_sample(dir_default[i]);
    run_random(150, -1, -1);
    end_phase();

    // log mode, default range; long result hold while samples keep coming
    configure(1'b1, 32'd0, 32'd65536, 512);
    foreach (dir_log[i]) send_sample(dir_log[i]);
    run_random(150, 60, -1);
    end_phase();

    // full output range, zero band; sender waits once for all results
    configure(1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 0);
    foreach (dir_zero[i]) send_sample(dir_zero[i]);
    run_random(150, -1, 75);
    end_phase();

    // log mode, full range, widest band
    configure(1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 32767);
    run_random(120, -1, -1);
    end_phase();

    // reversed range with no gaps on either side
    no_idle = 1'b1;
    configure(1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 100);
    run_random(150, -1, -1);
    end_phase();
    no_idle = 1'b0;

    // random settings
    for (int ph = 0; ph < 7; ph++) begin
      random_config();
      run_random(160, (ph == 2) ? 80 : -1, (ph == 4) ? 90 : -1);
      end_phase();
    end

    if (sb.error_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
